[rtl/sbh_pkg.sv]
// Shared types and codes for the sorted-table binary-search histogram.
// Used by sbh_seq and the top level; depends on nothing.
`timescale 1ns / 1ps

package sbh_pkg;

  // Item operation codes, carried on in_tuser
  localparam logic [1:0] MODE_LOAD     = 2'd0;
  localparam logic [1:0] MODE_CLASSIFY = 2'd1;
  localparam logic [1:0] MODE_READ     = 2'd2;
  localparam logic [1:0] MODE_CLEAR    = 2'd3;

  // Result kinds, carried on out_tuser
  localparam logic RK_CLASSIFY = 1'b0;
  localparam logic RK_READBACK = 1'b1;

  // Search kinds
  localparam logic KIND_INTERVAL = 1'b0;
  localparam logic KIND_DISCRETE = 1'b1;

  // Configuration register indexes
  localparam logic CFG_SEARCH_KIND    = 1'b0;
  localparam logic CFG_BOUNDARY_COUNT = 1'b1;

  typedef struct packed {
    logic       search_kind;
    logic [8:0] boundary_count;
  } sbh_cfg_t;

  typedef struct packed {
    logic        result_kind;
    logic [8:0]  bin_index;
    logic [31:0] bin_count;
    logic [31:0] miss_count;
  } sbh_result_t;

endpackage

[rtl/sbh_ram.sv]
// Simple dual-port synchronous RAM: one write port, one read port,
// read data registered. No dependencies.
`timescale 1ns / 1ps

module sbh_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 2,
  parameter int ADDR_W = 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/sbh_seq.sv]
// Search and count sequencer: boundary table RAM, bin count RAM, miss counter.
// Depends on sbh_pkg and sbh_ram.
`timescale 1ns / 1ps

module sbh_seq #(
  parameter int MAX_BINS    = 256,
  parameter int VALUE_WIDTH = 32,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sbh_pkg::sbh_cfg_t   cfg,
  input  logic                item_valid,
  output logic                item_ready,
  input  logic [1:0]          item_mode,
  input  logic [8:0]          item_slot,
  input  logic [31:0]         item_value,
  output logic                res_valid,
  input  logic                res_ready,
  output sbh_pkg::sbh_result_t res
);

  localparam int TA_W = $clog2(MAX_BINS + 1);
  localparam int IW   = $clog2(MAX_BINS + 2);
  localparam int CA_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int SW   = (IW > 9) ? IW : 9;
  localparam int VW   = VALUE_WIDTH;
  localparam int CW   = COUNT_WIDTH;
  localparam logic [VW-1:0] KEY_FLIP = {1'b1, {(VW-1){1'b0}}};

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LO    = 4'd2;
  localparam logic [3:0] S_HI    = 4'd3;
  localparam logic [3:0] S_PROBE = 4'd4;
  localparam logic [3:0] S_DLO   = 4'd5;
  localparam logic [3:0] S_DHI   = 4'd6;
  localparam logic [3:0] S_CNT   = 4'd7;
  localparam logic [3:0] S_UPD   = 4'd8;
  localparam logic [3:0] S_RB    = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]      state_r, state_nxt;
  logic [CA_W-1:0] clr_r, clr_nxt;
  logic [CW-1:0]   misses_r, misses_nxt;
  logic [VW-1:0]   key_r, key_nxt;
  logic            kind_r, kind_nxt;
  logic [TA_W-1:0] n_r, n_nxt;
  logic [IW-1:0]   lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt, idx_r, idx_nxt;
  logic            ge0_r, ge0_nxt;
  logic            rb_ok_r, rb_ok_nxt;
  logic            rk_r, rk_nxt;
  logic [CW-1:0]   cval_r, cval_nxt;

  logic            accept;
  logic            clr_accept;
  logic [SW-1:0]   slot_w;
  logic [SW-1:0]   bc_w;
  logic [TA_W-1:0] n_eff;
  logic [VW-1:0]   key_in;

  logic            tab_we;
  logic [TA_W-1:0] tab_raddr;
  logic [VW-1:0]   tdat;
  logic            cnt_we;
  logic [CA_W-1:0] cnt_waddr, cnt_raddr;
  logic [CW-1:0]   cnt_wdata, cdat, cnt_inc;

  logic            go_hi;
  logic [IW-1:0]   lo_n, hi_n, midc, idx_m1;
  logic [IW:0]     mid_sum;
  logic            more;
  logic            hi_in_range;
  logic [TA_W-1:0] last_addr;

  sbh_ram #(
    .DATA_W (VW),
    .DEPTH  (MAX_BINS + 1),
    .ADDR_W (TA_W)
  ) u_table (
    .clk   (clk),
    .we    (tab_we),
    .waddr (slot_w[TA_W-1:0]),
    .wdata (key_in),
    .raddr (tab_raddr),
    .rdata (tdat)
  );

  sbh_ram #(
    .DATA_W (CW),
    .DEPTH  (MAX_BINS),
    .ADDR_W (CA_W)
  ) u_counts (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cdat)
  );

  assign item_ready = (state_r == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign clr_accept = accept && (item_mode == sbh_pkg::MODE_CLEAR);
  assign slot_w     = SW'(item_slot);
  // Flip the sign bit so that unsigned compares follow two's complement order
  assign key_in     = VW'(item_value) ^ KEY_FLIP;
  assign bc_w       = SW'(cfg.boundary_count);
  assign tab_we     = accept && (item_mode == sbh_pkg::MODE_LOAD)
                      && (slot_w <= SW'(MAX_BINS));

  always_comb begin
    if (bc_w == '0) begin
      n_eff = TA_W'(1);
    end else if (bc_w > SW'(MAX_BINS)) begin
      n_eff = TA_W'(MAX_BINS);
    end else begin
      n_eff = bc_w[TA_W-1:0];
    end
  end

  assign cnt_inc     = (cdat == '1) ? cdat : cdat + CW'(1);
  assign idx_m1      = idx_r - IW'(1);
  assign last_addr   = (kind_r == sbh_pkg::KIND_DISCRETE) ? n_r - TA_W'(1) : n_r;

  // One probe: narrow the bracket on the table word returned for mid_r
  assign go_hi = (kind_r == sbh_pkg::KIND_DISCRETE) ? (key_r < tdat) : (key_r <= tdat);
  always_comb begin
    lo_n = lo_r;
    hi_n = hi_r;
    if (state_r == S_PROBE) begin
      if (go_hi) begin
        hi_n = mid_r;
      end else begin
        lo_n = mid_r;
      end
    end
  end
  assign mid_sum     = {1'b0, lo_n} + {1'b0, hi_n};
  assign midc        = mid_sum[IW:1];
  assign more        = (hi_n - lo_n) > IW'(1);
  assign hi_in_range = (hi_n != '0) && (hi_n <= IW'(n_r));

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    misses_nxt = misses_r;
    key_nxt    = key_r;
    kind_nxt   = kind_r;
    n_nxt      = n_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    mid_nxt    = mid_r;
    idx_nxt    = idx_r;
    ge0_nxt    = ge0_r;
    rb_ok_nxt  = rb_ok_r;
    rk_nxt     = rk_r;
    cval_nxt   = cval_r;
    tab_raddr  = '0;
    cnt_raddr  = idx_m1[CA_W-1:0];
    cnt_we     = 1'b0;
    cnt_waddr  = idx_m1[CA_W-1:0];
    cnt_wdata  = cnt_inc;
    res_valid  = 1'b0;

    case (state_r)
      S_CLR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_r;
        cnt_wdata = '0;
        clr_nxt   = clr_r + CA_W'(1);
        if (clr_r == CA_W'(MAX_BINS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        // table word 0 and the addressed count are fetched on every accept
        tab_raddr = '0;
        cnt_raddr = slot_w[CA_W-1:0];
        if (accept) begin
          key_nxt   = key_in;
          kind_nxt  = cfg.search_kind;
          n_nxt     = n_eff;
          rb_ok_nxt = slot_w < SW'(n_eff);
          case (item_mode)
            sbh_pkg::MODE_CLASSIFY: begin
              rk_nxt    = sbh_pkg::RK_CLASSIFY;
              state_nxt = S_LO;
            end
            sbh_pkg::MODE_READ: begin
              rk_nxt    = sbh_pkg::RK_READBACK;
              idx_nxt   = (slot_w < SW'(n_eff)) ? IW'(slot_w + SW'(1)) : '0;
              state_nxt = S_RB;
            end
            sbh_pkg::MODE_CLEAR: begin
              misses_nxt = '0;
              clr_nxt    = '0;
              state_nxt  = S_CLR;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_LO: begin
        ge0_nxt   = key_r >= tdat;
        tab_raddr = last_addr;
        lo_nxt    = '0;
        hi_nxt    = (kind_r == sbh_pkg::KIND_DISCRETE) ? IW'(n_r) - IW'(1)
                                                       : IW'(n_r) + IW'(1);
        state_nxt = S_HI;
      end
      S_HI: begin
        if (!(ge0_r && (key_r <= tdat))) begin
          idx_nxt   = '0;
          state_nxt = S_CNT;
        end else if (more) begin
          tab_raddr = midc[TA_W-1:0];
          mid_nxt   = midc;
          state_nxt = S_PROBE;
        end else begin
          tab_raddr = lo_r[TA_W-1:0];
          state_nxt = S_DLO;
        end
      end
      S_PROBE: begin
        lo_nxt = lo_n;
        hi_nxt = hi_n;
        if (more) begin
          tab_raddr = midc[TA_W-1:0];
          mid_nxt   = midc;
        end else if (kind_r == sbh_pkg::KIND_DISCRETE) begin
          tab_raddr = lo_n[TA_W-1:0];
          state_nxt = S_DLO;
        end else begin
          idx_nxt   = hi_in_range ? hi_n : '0;
          state_nxt = S_CNT;
        end
      end
      S_DLO: begin
        if (tdat == key_r) begin
          idx_nxt   = lo_r + IW'(1);
          state_nxt = S_CNT;
        end else begin
          tab_raddr = hi_r[TA_W-1:0];
          state_nxt = S_DHI;
        end
      end
      S_DHI: begin
        idx_nxt   = (tdat == key_r) ? hi_r + IW'(1) : '0;
        state_nxt = S_CNT;
      end
      S_CNT: begin
        if (idx_r != '0) begin
          state_nxt = S_UPD;
        end else begin
          misses_nxt = (misses_r == '1) ? misses_r : misses_r + CW'(1);
          cval_nxt   = '0;
          state_nxt  = S_OUT;
        end
      end
      S_UPD: begin
        cnt_we    = 1'b1;
        cval_nxt  = cnt_inc;
        state_nxt = S_OUT;
      end
      S_RB: begin
        cval_nxt  = rb_ok_r ? cdat : '0;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      clr_r    <= '0;
      misses_r <= '0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      misses_r <= misses_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    kind_r  <= kind_nxt;
    n_r     <= n_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    idx_r   <= idx_nxt;
    ge0_r   <= ge0_nxt;
    rb_ok_r <= rb_ok_nxt;
    rk_r    <= rk_nxt;
    cval_r  <= cval_nxt;
  end

  assign res.result_kind = rk_r;
  assign res.bin_index   = 9'(idx_r);
  assign res.bin_count   = 32'(cval_r);
  assign res.miss_count  = 32'(misses_r);

  // A probe address lies strictly inside the current bracket
  a_probe_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE) |-> (lo_r < mid_r) && (mid_r < hi_r))
    else $error("probe address outside search bracket");

  // A count update only ever touches a bin in use
  a_upd_bin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> (idx_r != '0) && (idx_r <= IW'(n_r)))
    else $error("count update outside active bins");

  // A reported bin never exceeds the bin count latched for the item
  a_res_bin: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (idx_r <= IW'(n_r)))
    else $error("reported bin above bin count");

  // The miss counter only falls on a clear
  a_miss_mono: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_accept |=> (misses_r >= $past(misses_r)))
    else $error("miss counter fell without a clear");

endmodule

[rtl/sorted_table_bin_search_histogram.sv]
// Top level of the sorted-table binary-search histogram: stream ports,
// configuration registers and the output beat register. Depends on sbh_pkg, sbh_seq.
//
// Items are handled one at a time. In a classify, each binary-search probe is
// one read of the boundary table RAM, and the bin count is a read-modify-write
// of the count RAM. A clear, and the period after reset, sweeps the count RAM
// one entry a cycle, during which in_tready stays low; configuration writes are
// taken at any time. Results are held in an output register, so the next item
// can start while a beat waits on out_tready. Only the order of values is used;
// load and clear items give no result beat.
`timescale 1ns / 1ps

module sorted_table_bin_search_histogram #(
  parameter int MAX_BINS    = 256,
  parameter int VALUE_WIDTH = 32,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // slot[8:0], value[40:9], zero pad[47:41]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // bin_index[8:0], bin_count[40:9],
                                  // miss_count[72:41], zero pad[79:73]
  output logic        out_tuser   // result_kind[0]
);

  sbh_pkg::sbh_cfg_t    cfg_r;
  sbh_pkg::sbh_result_t res;
  sbh_pkg::sbh_result_t out_r;
  logic                 res_valid;
  logic                 res_ready;
  logic                 out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.search_kind    <= sbh_pkg::KIND_INTERVAL;
      cfg_r.boundary_count <= 9'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        sbh_pkg::CFG_SEARCH_KIND:    cfg_r.search_kind    <= cfg_wdata[0];
        sbh_pkg::CFG_BOUNDARY_COUNT: cfg_r.boundary_count <= cfg_wdata;
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  sbh_seq #(
    .MAX_BINS    (MAX_BINS),
    .VALUE_WIDTH (VALUE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (in_tvalid),
    .item_ready (in_tready),
    .item_mode  (in_tuser),
    .item_slot  (in_tdata[8:0]),
    .item_value (in_tdata[40:9]),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // Take a new result when the held beat is gone or leaves this cycle
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.result_kind;
  assign out_tdata  = {7'd0, out_r.miss_count, out_r.bin_count, out_r.bin_index};

endmodule

[test/tb_sorted_table_bin_search_histogram.sv]
// Self-checking bench for the sorted-table binary-search histogram: table loads,
// interval and exact-match classification, count readback and clears, with stalls.
// Depends on sbh_pkg and the sorted_table_bin_search_histogram top level.
`timescale 1ns / 1ps

module tb_sorted_table_bin_search_histogram;

  localparam int NUM_BINS   = 256;
  localparam int QUIET_WAIT = 300;   // covers a clear sweep of the count RAM
  localparam int HOLD_OFF   = 200;
  localparam int STUCK_MAX  = 5000;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_ITEMS = 25;

  typedef struct packed {
    logic [1:0]           mode;
    logic [8:0]           slot;
    logic [31:0]          value;
    logic                 typed;
    sbh_pkg::sbh_result_t res;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [8:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;    // slot[8:0], value[40:9], zero pad[47:41]
  logic [1:0]  in_tuser;    // mode[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;   // bin_index[8:0], bin_count[40:9], miss_count[72:41], pad
  logic        out_tuser;   // result_kind[0]

  // Predicted block state
  logic [31:0] bound_key [NUM_BINS+1];
  bit          slot_loaded [NUM_BINS+1];
  logic [31:0] hit_tally [NUM_BINS];
  logic [31:0] miss_tally;
  logic        search_kind_q;
  logic [8:0]  bin_total_q;

  sbh_pkg::sbh_result_t bins_due [$];
  int          failures;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_off_req;
  int          stuck_cycles;

  dir_row_t directed_rows [24] = '{
    '{sbh_pkg::MODE_READ, 9'd0, 32'd0, 1'b1,
      '{sbh_pkg::RK_READBACK, 9'd1, 32'd0, 32'd0}},
    '{sbh_pkg::MODE_READ, 9'd511, 32'd0, 1'b1,
      '{sbh_pkg::RK_READBACK, 9'd0, 32'd0, 32'd0}},
    '{sbh_pkg::MODE_LOAD,     9'd0,   32'h8000_0000,  1'b0, '0},
    '{sbh_pkg::MODE_LOAD,     9'd1,   32'hFFFF_FF9C,  1'b0, '0},
    '{sbh_pkg::MODE_LOAD,     9'd2,   32'd0,          1'b0, '0},
    '{sbh_pkg::MODE_LOAD,     9'd3,   32'd100,        1'b0, '0},
    '{sbh_pkg::MODE_LOAD,     9'd4,   32'h7FFF_FFFF,  1'b0, '0},
    '{sbh_pkg::MODE_LOAD,     9'd511, 32'd5,          1'b0, '0},
    '{sbh_pkg::MODE_LOAD,     9'd257, 32'd5,          1'b0, '0},
    '{sbh_pkg::MODE_CLASSIFY, 9'd0, 32'h8000_0000, 1'b1,
      '{sbh_pkg::RK_CLASSIFY, 9'd1, 32'd1, 32'd0}},
    '{sbh_pkg::MODE_CLASSIFY, 9'd0, 32'h7FFF_FFFF, 1'b1,
      '{sbh_pkg::RK_CLASSIFY, 9'd4, 32'd1, 32'd0}},
    '{sbh_pkg::MODE_CLASSIFY, 9'd0, 32'hFFFF_FF9C, 1'b1,
      '{sbh_pkg::RK_CLASSIFY, 9'd1, 32'd2, 32'd0}},
    '{sbh_pkg::MODE_CLASSIFY, 9'd0,   32'hFFFF_FF9D,  1'b0, '0},
    '{sbh_pkg::MODE_CLASSIFY, 9'd0,   32'd1,          1'b0, '0},
    '{sbh_pkg::MODE_READ,     9'd0,   32'd0,          1'b0, '0},
    '{sbh_pkg::MODE_CLEAR,    9'd0,   32'd0,          1'b0, '0},
    '{sbh_pkg::MODE_READ, 9'd3, 32'd0, 1'b1,
      '{sbh_pkg::RK_READBACK, 9'd4, 32'd0, 32'd0}},
    '{sbh_pkg::MODE_LOAD,     9'd4,   32'd1000,       1'b0, '0},
    '{sbh_pkg::MODE_CLASSIFY, 9'd0, 32'd2000, 1'b1,
      '{sbh_pkg::RK_CLASSIFY, 9'd0, 32'd0, 32'd1}},
    '{sbh_pkg::MODE_LOAD,     9'd0,   32'hFFFF_FC18,  1'b0, '0},
    '{sbh_pkg::MODE_CLASSIFY, 9'd0,   32'hFFFF_FC17,  1'b0, '0},
    // break the ordering: the search must still land on a legal bin or miss
    '{sbh_pkg::MODE_LOAD,     9'd2,   32'd5000,       1'b0, '0},
    '{sbh_pkg::MODE_CLASSIFY, 9'd0,   32'd50,         1'b0, '0},
    '{sbh_pkg::MODE_CLASSIFY, 9'h1FF, 32'd100,        1'b0, '0}
  };

  sorted_table_bin_search_histogram #(
    .MAX_BINS    (NUM_BINS),
    .VALUE_WIDTH (32),
    .COUNT_WIDTH (32)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned bins_in_use();
    if (bin_total_q == 9'd0) return 1;
    if (bin_total_q > NUM_BINS) return NUM_BINS;
    return bin_total_q;
  endfunction

  function automatic int unsigned find_interval(logic [31:0] key, int unsigned n);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = n + 1;
    if (!(bound_key[0] <= key && key <= bound_key[n])) return 0;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (key <= bound_key[mid]) hi = mid;
      else lo = mid;
    end
    return (hi >= 1 && hi <= n) ? hi : 0;
  endfunction

  function automatic int unsigned find_match(logic [31:0] key, int unsigned n);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = n - 1;
    if (!(bound_key[0] <= key && key <= bound_key[n-1])) return 0;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (key < bound_key[mid]) hi = mid;
      else lo = mid;
    end
    if (bound_key[lo] == key) return lo + 1;
    if (bound_key[hi] == key) return hi + 1;
    return 0;
  endfunction

  task automatic predict_item(input logic [1:0] mode, input logic [8:0] slot,
                              input logic [31:0] value, output bit has_result,
                              output sbh_pkg::sbh_result_t res);
    logic [31:0] key;
    int unsigned n, idx;
    // flip the sign bit so that unsigned order matches signed order
    key = value ^ 32'h8000_0000;
    n = bins_in_use();
    has_result = 1'b0;
    res = '0;
    case (mode)
      sbh_pkg::MODE_LOAD: begin
        if (slot <= NUM_BINS) begin
          bound_key[slot] = key;
          slot_loaded[slot] = 1'b1;
        end
      end
      sbh_pkg::MODE_CLEAR: begin
        foreach (hit_tally[b]) hit_tally[b] = '0;
        miss_tally = '0;
      end
      sbh_pkg::MODE_CLASSIFY: begin
        idx = (search_kind_q == sbh_pkg::KIND_DISCRETE) ? find_match(key, n)
                                                        : find_interval(key, n);
        has_result = 1'b1;
        res.result_kind = sbh_pkg::RK_CLASSIFY;
        if (idx >= 1 && idx <= NUM_BINS) begin
          if (hit_tally[idx-1] != '1) hit_tally[idx-1]++;
          res.bin_index = idx[8:0];
          res.bin_count = hit_tally[idx-1];
        end else if (miss_tally != '1) begin
          miss_tally++;
        end
        res.miss_count = miss_tally;
      end
      default: begin
        has_result = 1'b1;
        res.result_kind = sbh_pkg::RK_READBACK;
        if (slot < n) begin
          res.bin_index = slot + 9'd1;
          res.bin_count = hit_tally[slot];
        end
        res.miss_count = miss_tally;
      end
    endcase
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic offer_item(input logic [1:0] mode, input logic [8:0] slot,
                            input logic [31:0] value, input logic typed,
                            input sbh_pkg::sbh_result_t typed_res);
    bit                   has_result;
    sbh_pkg::sbh_result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {7'd0, value, slot};
    do @(posedge clk); while (!in_tready);
    predict_item(mode, slot, value, has_result, res);
    if (has_result) bins_due.push_back(typed ? typed_res : res);
    @(negedge clk);
  endtask

  task automatic set_mode_regs(input logic [8:0] kind_data, input logic [8:0] count_data);
    cfg_we    <= 1'b1;
    cfg_index <= sbh_pkg::CFG_SEARCH_KIND;
    cfg_wdata <= kind_data;
    @(posedge clk);
    search_kind_q = kind_data[0];
    @(negedge clk);
    cfg_index <= sbh_pkg::CFG_BOUNDARY_COUNT;
    cfg_wdata <= count_data;
    @(posedge clk);
    bin_total_q = count_data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drop valid, wait for every outstanding result, then let a clear sweep finish.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (bins_due.size() != 0) @(negedge clk);
    repeat (QUIET_WAIT) @(negedge clk);
  endtask

  task automatic load_sorted_table(input int unsigned n);
    logic [31:0] key, step_max;
    step_max = 32'hFFFF_FFFF / (n + 2);
    key = $urandom_range(0, step_max);
    for (int j = 0; j <= n; j++) begin
      offer_item(sbh_pkg::MODE_LOAD, j[8:0], key ^ 32'h8000_0000, 1'b0, '0);
      key = key + $urandom_range(1, step_max);
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      failures++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    sbh_pkg::sbh_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (bins_due.size() == 0) begin
        failures++;
        $display("%0t: result beat with nothing expected, expected none, actual %h/%b",
                 $time, out_tdata, out_tuser);
      end else begin
        want = bins_due.pop_front();
        compare_field("result_kind", {31'd0, want.result_kind}, {31'd0, out_tuser});
        compare_field("bin_index", {23'd0, want.bin_index}, {23'd0, out_tdata[8:0]});
        compare_field("bin_count", want.bin_count, out_tdata[40:9]);
        compare_field("miss_count", want.miss_count, out_tdata[72:41]);
      end
    end
  end

  initial begin
    int hold_off_seen;
    hold_off_seen = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req != hold_off_seen) begin
        hold_off_seen = hold_off_req;
        // hold the result side while the sender keeps offering
        for (int k = 0; k < HOLD_OFF; k++) begin
          out_tready <= 1'b0;
          @(negedge clk);
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_MAX) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    logic [8:0]  count_writes [NUM_PHASES];
    logic        kinds [NUM_PHASES];
    int unsigned n, top;
    int          r;
    bit          reload;
    logic [31:0] key, value;
    logic [8:0]  slot;

    count_writes = '{9'd0, 9'd1, 9'd3, 9'd7, 9'd16, 9'd511, 9'd256, 9'd12};
    kinds        = '{sbh_pkg::KIND_INTERVAL, sbh_pkg::KIND_DISCRETE,
                     sbh_pkg::KIND_INTERVAL, sbh_pkg::KIND_DISCRETE,
                     sbh_pkg::KIND_DISCRETE, sbh_pkg::KIND_INTERVAL,
                     sbh_pkg::KIND_DISCRETE, sbh_pkg::KIND_INTERVAL};
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_req = 0;
    foreach (bound_key[i]) begin
      bound_key[i] = '0;
      slot_loaded[i] = 1'b0;
    end
    foreach (hit_tally[i]) hit_tally[i] = '0;
    miss_tally = '0;
    search_kind_q = sbh_pkg::KIND_INTERVAL;
    bin_total_q = 9'd1;

    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = sbh_pkg::CFG_SEARCH_KIND;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = sbh_pkg::MODE_LOAD;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_mode_regs({8'd0, sbh_pkg::KIND_INTERVAL}, 9'd4);
    foreach (directed_rows[i])
      offer_item(directed_rows[i].mode, directed_rows[i].slot, directed_rows[i].value,
                 directed_rows[i].typed, directed_rows[i].res);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_mode_regs({8'($urandom_range(0, 255)), kinds[p]}, count_writes[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      n = bins_in_use();
      reload = (n <= 32);
      for (int j = 0; j <= n; j++)
        if (!slot_loaded[j]) reload = 1'b1;
      if (reload) load_sorted_table(n);
      if (p == 4) hold_off_req++;

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          top = (search_kind_q == sbh_pkg::KIND_DISCRETE) ? n - 1 : n;
          if ($urandom_range(0, 4) == 0) begin
            value = $urandom();
          end else begin
            // land on, just below or just above a boundary
            key = bound_key[$urandom_range(0, top)] + $urandom_range(0, 2) - 1;
            value = key ^ 32'h8000_0000;
          end
          offer_item(sbh_pkg::MODE_CLASSIFY, 9'($urandom_range(0, 511)), value, 1'b0, '0);
        end else if (r < 80) begin
          slot = ($urandom_range(0, 3) != 0) ? 9'($urandom_range(0, n + 1))
                                             : 9'($urandom_range(0, 511));
          offer_item(sbh_pkg::MODE_READ, slot, $urandom(), 1'b0, '0);
        end else if (r < 85) begin
          offer_item(sbh_pkg::MODE_CLEAR, 9'($urandom_range(0, 511)), $urandom(), 1'b0, '0);
        end else begin
          offer_item(sbh_pkg::MODE_LOAD, 9'($urandom_range(0, 511)), $urandom(), 1'b0, '0);
        end
      end
      drain();
    end

    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
